// ===== design/bksf_pkg.sv =====
package bksf_pkg;

  localparam int ENTRIES = 8;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int RD_N    = (ENTRIES < 8) ? ENTRIES : 8;
  localparam int CMP_W   = (CNT_W > 3) ? CNT_W : 3;

  localparam logic [1:0] KIND_QUERY = 2'd0;
  localparam logic [1:0] KIND_PIN   = 2'd1;
  localparam logic [1:0] KIND_UNPIN = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key;
    logic [2:0]  index;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [2:0]  position;
    logic [3:0]  entry_count;
    logic [63:0] entry_key;
    logic        changed;
    logic        evicted;
  } rsp_t;

  // per-cycle commands broadcast along the cell row
  typedef struct packed {
    logic pin_new;
    logic unpin;
    logic evict;
  } cell_cmd_t;

endpackage

// ===== design/bksf_cell.sv =====
module bksf_cell (
  input  logic                clk,
  input  bksf_pkg::cell_cmd_t cmd,
  input  logic [63:0]         probe_key,
  input  logic                live,
  input  logic                tail,
  input  logic                chain_in,
  input  logic [63:0]         right_key,
  output logic                match,
  output logic                chain_out,
  output logic [63:0]         stored
);
  import bksf_pkg::*;

  logic [63:0] key;
  logic [63:0] key_next;
  logic        shift;
  logic        load;

  assign match     = live && (key == probe_key);
  assign chain_out = chain_in | match;
  assign stored    = key;

  // unpin closes the gap from the matching slot upward; eviction moves everything
  assign shift = cmd.evict | (cmd.unpin & chain_out);
  assign load  = cmd.pin_new & ~cmd.evict & tail;

  always_comb begin
    key_next = key;
    if (load) begin
      key_next = probe_key;
    end else if (shift) begin
      key_next = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

// ===== design/bounded_key_set_fifo_evict_top.sv =====
// a request is held in item; its response registers when the output side can take it
// no new request is taken until the current one has moved its response to the output
// all slots compare in parallel and shift by one cell in the same cycle
// reset empties the list (count cleared); slot keys are left as they are
module bounded_key_set_fifo_evict_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  bksf_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bksf_pkg::rsp_t rsp
);
  import bksf_pkg::*;

  logic               busy;
  req_t               item;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               fire;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES:0]   chain;
  logic [63:0]        stored [ENTRIES];
  logic [ENTRIES-1:0] live;
  logic [ENTRIES-1:0] tail;
  cell_cmd_t          cmd;

  logic               hit;
  logic               full;
  logic               is_pin;
  logic               is_unpin;
  logic               is_read;
  logic               rd_ok;
  logic [2:0]         hit_pos;
  logic [63:0]        rd_key;
  rsp_t               rsp_next;

  assign req_ready = ~busy;
  assign fire      = busy & (~rsp_valid | rsp_ready);

  assign is_pin   = item.kind == KIND_PIN;
  assign is_unpin = item.kind == KIND_UNPIN;
  assign is_read  = item.kind == KIND_READ;

  assign hit  = chain[ENTRIES];
  assign full = count == CNT_W'(ENTRIES);

  assign cmd.pin_new = fire & is_pin & ~hit;
  assign cmd.unpin   = fire & is_unpin & hit;
  assign cmd.evict   = fire & is_pin & ~hit & full;

  assign chain[0] = 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [63:0] rkey;
    assign live[i] = CNT_W'(i) < count;
    assign tail[i] = CNT_W'(i) == count;
    if (i == ENTRIES - 1) begin : g_last
      // the last cell takes the new key when everything moves down
      assign rkey = item.key;
    end else begin : g_mid
      assign rkey = stored[i+1];
    end
    bksf_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .probe_key (item.key),
      .live      (live[i]),
      .tail      (tail[i]),
      .chain_in  (chain[i]),
      .right_key (rkey),
      .match     (match[i]),
      .chain_out (chain[i+1]),
      .stored    (stored[i])
    );
  end

  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        hit_pos = hit_pos | 3'(i);
      end
    end
  end

  assign rd_ok = CMP_W'(item.index) < CMP_W'(count);

  always_comb begin
    rd_key = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (item.index == 3'(i)) begin
        rd_key = stored[i];
      end
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.pin_new && !full) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.unpin) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    rsp_next.found       = is_read ? rd_ok : hit;
    rsp_next.position    = is_read ? 3'd0 : hit_pos;
    rsp_next.entry_count = 4'(count_next);
    rsp_next.entry_key   = (is_read && rd_ok) ? rd_key : 64'd0;
    rsp_next.changed     = cmd.pin_new | cmd.unpin;
    rsp_next.evicted     = cmd.evict;
    if (cmd.pin_new) begin
      rsp_next.position = full ? 3'(ENTRIES - 1) : 3'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (req_valid && req_ready) begin
        busy <= 1'b1;
      end else if (fire) begin
        busy <= 1'b0;
      end
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req;
    end
    if (fire) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== tb/sv/bounded_key_set_fifo_evict_top_test.sv =====
`timescale 1ns / 1ps

module bounded_key_set_fifo_evict_top_test;
  import bksf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned TAIL_ITEMS  = 150;
  localparam int unsigned RAND_ITEMS  = 1030;
  localparam int unsigned POOL_N      = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  bounded_key_set_fifo_evict_top uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #2 clk = ~clk;

  // shadow copy of the key list, oldest at slot 0
  logic [63:0] shadow_keys [ENTRIES];
  int unsigned shadow_count = 0;

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  int unsigned in_flight = 0;
  int unsigned sent_count = 0;
  int unsigned recv_count = 0;
  int unsigned quiet_from = 32'hFFFF_FFFF;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  logic [63:0] key_pool [POOL_N];

  function automatic rsp_t apply_to_key_set(req_t r);
    rsp_t o;
    int hit_at;
    int i;
    o = '0;
    hit_at = -1;
    if (r.kind == KIND_READ) begin
      if (r.index < shadow_count && r.index < ENTRIES) begin
        o.found = 1'b1;
        o.entry_key = shadow_keys[r.index];
      end
    end else begin
      for (i = 0; i < shadow_count && i < ENTRIES; i++)
        if (hit_at < 0 && shadow_keys[i] == r.key) hit_at = i;
      o.found = (hit_at >= 0);
      o.position = (hit_at >= 0) ? hit_at[2:0] : 3'd0;
      if (r.kind == KIND_PIN && hit_at < 0) begin
        if (shadow_count >= ENTRIES) begin
          for (i = 0; i + 1 < ENTRIES; i++) shadow_keys[i] = shadow_keys[i + 1];
          shadow_count = ENTRIES - 1;
          o.evicted = 1'b1;
        end
        shadow_keys[shadow_count] = r.key;
        o.position = shadow_count[2:0];
        shadow_count++;
        o.changed = 1'b1;
      end else if (r.kind == KIND_UNPIN && hit_at >= 0) begin
        for (i = hit_at; i + 1 < shadow_count && i + 1 < ENTRIES; i++)
          shadow_keys[i] = shadow_keys[i + 1];
        shadow_count--;
        o.changed = 1'b1;
      end
    end
    o.entry_count = shadow_count[3:0];
    return o;
  endfunction

  function automatic req_t make_req(logic [1:0] kind, logic [63:0] key, logic [2:0] index);
    req_t r;
    r.kind = kind;
    r.key = key;
    r.index = index;
    return r;
  endfunction

  function automatic logic [63:0] any_key();
    return {$urandom, $urandom};
  endfunction

  // mostly reuse a small pool so pins collide and the list fills and evicts
  function automatic logic [63:0] pick_key();
    int unsigned sel;
    int unsigned roll;
    logic [63:0] k;
    sel = $urandom_range(0, POOL_N - 1);
    roll = $urandom_range(0, 9);
    k = key_pool[sel];
    if (roll == 7) begin
      k[$urandom_range(0, 63)] ^= 1'b1;
    end else if (roll == 8) begin
      k = any_key();
    end else if (roll == 9) begin
      key_pool[sel] = any_key();
      k = key_pool[sel];
    end
    return k;
  endfunction

  // driver: one request transfer at a time, random send gaps
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        expected_rsps.push_back(apply_to_key_set(req));
        sent_count++;
      end
      if (!req_valid || req_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          req_valid <= 1'b0;
        end else if (sent_count < quiet_from && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 13) - 1;
          req_valid <= 1'b0;
        end else begin
          req <= pending_reqs.pop_front();
          in_flight++;
          req_valid <= 1'b1;
        end
      end
    end
  end

  // monitor: compare each response transfer with the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        recv_count++;
        if (expected_rsps.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected response: found=%0b pos=%0d cnt=%0d key=%h chg=%0b ev=%0b",
                     rsp.found, rsp.position, rsp.entry_count, rsp.entry_key,
                     rsp.changed, rsp.evicted);
        end else begin
          want = expected_rsps.pop_front();
          in_flight--;
          if (rsp.found !== want.found || rsp.position !== want.position ||
              rsp.entry_count !== want.entry_count || rsp.entry_key !== want.entry_key ||
              rsp.changed !== want.changed || rsp.evicted !== want.evicted) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch at response %0d", recv_count);
              $display("  exp found=%0b pos=%0d cnt=%0d key=%h chg=%0b ev=%0b",
                       want.found, want.position, want.entry_count, want.entry_key,
                       want.changed, want.evicted);
              $display("  got found=%0b pos=%0d cnt=%0d key=%h chg=%0b ev=%0b",
                       rsp.found, rsp.position, rsp.entry_count, rsp.entry_key,
                       rsp.changed, rsp.evicted);
            end
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        rsp_ready <= 1'b0;
      end else if (recv_count < quiet_from && $urandom_range(0, 9) == 0) begin
        recv_stall = $urandom_range(1, 13) - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned roll;
    int unsigned total;
    logic [1:0] kind;
    for (int i = 0; i < POOL_N; i++) key_pool[i] = any_key();
    key_pool[0] = 64'h0;
    key_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    key_pool[2] = 64'h4D53_4654_0000_0000;
    key_pool[3] = 64'h4E56_4441_0000_0000;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, zero and all-ones keys, one-bit neighbors, fill and evict
    pending_reqs.push_back(make_req(KIND_QUERY, 64'h0, 3'd0));
    pending_reqs.push_back(make_req(KIND_READ, 64'h0, 3'd0));
    pending_reqs.push_back(make_req(KIND_READ, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7));
    pending_reqs.push_back(make_req(KIND_UNPIN, 64'h1234, 3'd0));
    pending_reqs.push_back(make_req(KIND_PIN, 64'h0, 3'd0));
    pending_reqs.push_back(make_req(KIND_PIN, 64'h0, 3'd7));
    pending_reqs.push_back(make_req(KIND_QUERY, 64'h0, 3'd0));
    pending_reqs.push_back(make_req(KIND_PIN, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0));
    pending_reqs.push_back(make_req(KIND_PIN, 64'h1, 3'd0));
    pending_reqs.push_back(make_req(KIND_PIN, 64'h8000_0000_0000_0000, 3'd0));
    pending_reqs.push_back(make_req(KIND_QUERY, 64'hFFFF_FFFF_FFFF_FFFE, 3'd0));
    pending_reqs.push_back(make_req(KIND_PIN, 64'h4141_504C_0000_0000, 3'd0));
    pending_reqs.push_back(make_req(KIND_PIN, 64'h4D53_4654_0000_0000, 3'd0));
    pending_reqs.push_back(make_req(KIND_PIN, 64'h474F_4F47_0000_0000, 3'd0));
    pending_reqs.push_back(make_req(KIND_PIN, 64'h414D_5A4E_0000_0000, 3'd0));
    pending_reqs.push_back(make_req(KIND_PIN, 64'h5453_4C41_0000_0000, 3'd0));
    pending_reqs.push_back(make_req(KIND_QUERY, 64'h0, 3'd0));
    pending_reqs.push_back(make_req(KIND_UNPIN, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0));
    pending_reqs.push_back(make_req(KIND_UNPIN, 64'h5453_4C41_0000_0000, 3'd0));
    pending_reqs.push_back(make_req(KIND_PIN, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0));
    pending_reqs.push_back(make_req(KIND_READ, 64'h0, 3'd0));
    pending_reqs.push_back(make_req(KIND_READ, 64'h0, 3'd5));
    pending_reqs.push_back(make_req(KIND_READ, 64'h0, 3'd6));
    pending_reqs.push_back(make_req(KIND_READ, 64'h0, 3'd7));
    total = pending_reqs.size() + RAND_ITEMS;

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // hold off until the block has drained, once early and once midway
      if (n == 0 || n == RAND_ITEMS / 2)
        while (pending_reqs.size() != 0 || in_flight != 0) @(posedge clk);
      if (n == RAND_ITEMS / 2) quiet_from = total - TAIL_ITEMS;
      roll = $urandom_range(0, 99);
      if (roll < 40) kind = KIND_PIN;
      else if (roll < 60) kind = KIND_UNPIN;
      else if (roll < 80) kind = KIND_QUERY;
      else kind = KIND_READ;
      pending_reqs.push_back(make_req(kind,
                                      (kind == KIND_READ) ? any_key() : pick_key(),
                                      3'($urandom_range(0, 7))));
    end

    while (pending_reqs.size() != 0 || in_flight != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_rsps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
